// ----- rtl/fxa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, field widths and parameter defaults shared by the ALU files.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int unsigned CmdBits       = 4;
  localparam int unsigned DataBits      = 32;
  localparam int          FractionBitsD = 8;
  localparam int          WordBitsD     = 32;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

endpackage

// ----- rtl/fxa_if.sv -----
// ----------------------------------------------------------------------------
// Fixed-point ALU channels
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
interface fxa_req_if import fxa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CmdBits-1:0]          cmd;
  logic signed [DataBits-1:0]  operand_a;
  logic signed [DataBits-1:0]  operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface fxa_rsp_if import fxa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DataBits-1:0]  result_raw;
  logic                        compare_true;
  logic                        overflow;
  logic                        divide_by_zero;

  modport source (output valid, result_raw, compare_true, overflow, divide_by_zero,
                  input ready);
  modport sink   (input valid, result_raw, compare_true, overflow, divide_by_zero,
                  output ready);
endinterface

// ----- rtl/fixed_point_alu.sv -----
// Every operation takes the same path through the pipeline.
// Throughput: one transaction per cycle while results are taken; the divider
// retires one quotient bit per pipeline stage, which sets the depth.
// The whole pipeline advances together and holds while a result waits.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Pipelined signed fixed-point arithmetic with rounding and saturation.
// ----------------------------------------------------------------------------
module fixed_point_alu import fxa_pkg::*; #(
  parameter int FRACTION_BITS = FractionBitsD,
  parameter int WORD_BITS     = WordBitsD
) (
  input  logic       clk,
  input  logic       rst_n,
  fxa_req_if.sink    in_ch,
  fxa_rsp_if.source  out_ch
);

  localparam int EW = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
  localparam int EF = (FRACTION_BITS > 16) ? 16 : ((FRACTION_BITS < 0) ? 0 : FRACTION_BITS);
  localparam int NQ = DataBits + EF;
  localparam logic signed [63:0] HI   = (64'sd1 <<< (EW - 1)) - 64'sd1;
  localparam logic signed [63:0] LO   = -HI - 64'sd1;
  localparam logic [63:0]        HALF = (64'd1 << EF) >> 1;

  logic en;

  // Pipeline stage registers: stage 0 holds the prepared operands, stages
  // 1..NQ each resolve one quotient bit.
  logic [NQ:0]              v_r;
  cmd_t                     cmd_r  [0:NQ];
  logic signed [63:0]       wide_r [0:NQ];
  logic                     cmp_r  [0:NQ];
  logic                     dz_r   [0:NQ];
  logic                     neg_r  [0:NQ];
  logic [NQ-1:0]            num_r  [0:NQ];
  logic [DataBits-1:0]      den_r  [0:NQ];
  logic [DataBits-1:0]      rem_r  [0:NQ];

  logic signed [63:0]       a64, b64, wide_nxt;
  logic                     cmp_nxt, dz_nxt, neg_nxt;
  logic [DataBits-1:0]      mag_a, mag_b;

  logic [DataBits:0]        shift_w [1:NQ];
  logic                     ge_w    [1:NQ];
  logic [DataBits-1:0]      rem_w   [1:NQ];

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    a64      = 64'(in_ch.operand_a);
    b64      = 64'(in_ch.operand_b);
    mag_a    = in_ch.operand_a[DataBits-1] ? DataBits'(-a64) : DataBits'(a64);
    mag_b    = in_ch.operand_b[DataBits-1] ? DataBits'(-b64) : DataBits'(b64);
    neg_nxt  = in_ch.operand_a[DataBits-1] ^ in_ch.operand_b[DataBits-1];
    dz_nxt   = 1'b0;
    cmp_nxt  = 1'b0;
    wide_nxt = '0;
    case (cmd_t'(in_ch.cmd))
      CMD_ADD:      wide_nxt = a64 + b64;
      CMD_SUB:      wide_nxt = a64 - b64;
      CMD_MUL:      wide_nxt = in_ch.operand_a * in_ch.operand_b;
      CMD_DIV: begin
        dz_nxt = (in_ch.operand_b == '0);
        // A zero divisor saturates toward the dividend's sign.
        if (a64 > 0) begin
          wide_nxt = HI;
        end else if (a64 < 0) begin
          wide_nxt = LO;
        end
      end
      CMD_GT:       cmp_nxt = a64 > b64;
      CMD_LT:       cmp_nxt = a64 < b64;
      CMD_GE:       cmp_nxt = a64 >= b64;
      CMD_LE:       cmp_nxt = a64 <= b64;
      CMD_EQ:       cmp_nxt = a64 == b64;
      CMD_NE:       cmp_nxt = a64 != b64;
      CMD_MIN:      wide_nxt = (a64 < b64) ? a64 : b64;
      CMD_MAX:      wide_nxt = (a64 > b64) ? a64 : b64;
      CMD_INC:      wide_nxt = a64 + 64'sd1;
      CMD_DEC:      wide_nxt = a64 - 64'sd1;
      CMD_FROM_INT: wide_nxt = a64 <<< EF;
      CMD_TO_INT:   wide_nxt = a64 >>> EF;
      default:      wide_nxt = '0;
    endcase
  end

  // One restoring division step per stage.
  always_comb begin
    for (int k = 1; k <= NQ; k++) begin
      shift_w[k] = {rem_r[k-1], num_r[k-1][NQ-1]};
      ge_w[k]    = (shift_w[k] >= {1'b0, den_r[k-1]});
      rem_w[k]   = ge_w[k] ? DataBits'(shift_w[k] - {1'b0, den_r[k-1]})
                           : DataBits'(shift_w[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NQ-1:0], in_ch.valid};
    end
    if (en) begin
      cmd_r[0]  <= cmd_t'(in_ch.cmd);
      wide_r[0] <= wide_nxt;
      cmp_r[0]  <= cmp_nxt;
      dz_r[0]   <= dz_nxt;
      neg_r[0]  <= neg_nxt;
      num_r[0]  <= NQ'(mag_a) << EF;
      den_r[0]  <= mag_b;
      rem_r[0]  <= '0;
      for (int k = 1; k <= NQ; k++) begin
        cmd_r[k]  <= cmd_r[k-1];
        wide_r[k] <= wide_r[k-1];
        cmp_r[k]  <= cmp_r[k-1];
        dz_r[k]   <= dz_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        num_r[k]  <= {num_r[k-1][NQ-2:0], ge_w[k]};
        den_r[k]  <= den_r[k-1];
        rem_r[k]  <= rem_w[k];
      end
    end
  end

  // Final stage: rounding, sign and saturation.
  logic [63:0]             mag_p, q_mag;
  logic signed [63:0]      val;
  logic signed [DataBits-1:0] res_nxt;
  logic                    ovf_nxt;
  logic                    out_valid_r, cmp_out_r, ovf_r, dz_out_r;
  logic signed [DataBits-1:0] res_r;

  always_comb begin
    mag_p = wide_r[NQ][63] ? 64'(-wide_r[NQ]) : 64'(wide_r[NQ]);
    q_mag = '0;
    val   = wide_r[NQ];
    case (cmd_r[NQ])
      CMD_MUL: begin
        q_mag = (mag_p + HALF) >> EF;
        val   = wide_r[NQ][63] ? -$signed(q_mag) : $signed(q_mag);
      end
      CMD_DIV: begin
        if (!dz_r[NQ]) begin
          // Ties round away from zero: bump when twice the remainder reaches d.
          q_mag = 64'(num_r[NQ]) +
                  64'({rem_r[NQ], 1'b0} >= {1'b0, den_r[NQ]});
          val   = neg_r[NQ] ? -$signed(q_mag) : $signed(q_mag);
        end
      end
      default: val = wide_r[NQ];
    endcase
    ovf_nxt = 1'b0;
    if (val > HI) begin
      res_nxt = DataBits'(HI);
      ovf_nxt = 1'b1;
    end else if (val < LO) begin
      res_nxt = DataBits'(LO);
      ovf_nxt = 1'b1;
    end else begin
      res_nxt = DataBits'(val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NQ];
    end
    if (en) begin
      res_r     <= res_nxt;
      cmp_out_r <= cmp_r[NQ];
      ovf_r     <= ovf_nxt && !dz_r[NQ];
      dz_out_r  <= dz_r[NQ];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_raw     = res_r;
  assign out_ch.compare_true   = cmp_out_r;
  assign out_ch.overflow       = ovf_r;
  assign out_ch.divide_by_zero = dz_out_r;

endmodule

// ----- rtl/fxa_checker.sv -----
// ----------------------------------------------------------------------------
// Fixed-point ALU port checker
// Checks result flags and handshake behaviour seen at the ALU's ports.
// ----------------------------------------------------------------------------
module fxa_checker import fxa_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [DataBits-1:0] out_result_raw,
  input logic                       out_compare_true,
  input logic                       out_overflow,
  input logic                       out_divide_by_zero
);

  // A result that is not taken holds for the next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_raw) &&
      $stable(out_compare_true) && $stable(out_overflow) && $stable(out_divide_by_zero))
    else $error("result changed while stalled");

  a_dz_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_overflow && !out_compare_true)
    else $error("divide by zero raised other flags");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_raw == '0 && !out_overflow)
    else $error("comparison produced a non-zero word");

  // With no result pending the pipeline must take a new transaction.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fixed_point_alu fxa_checker u_fxa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_result_raw     (out_ch.result_raw),
  .out_compare_true   (out_ch.compare_true),
  .out_overflow       (out_ch.overflow),
  .out_divide_by_zero (out_ch.divide_by_zero)
);

// ----- dv/fxa_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench types
// Transaction types shared by the testbench; the channel interfaces
// themselves come from the RTL.
// ----------------------------------------------------------------------------
package fxa_tb_pkg;
  import fxa_pkg::*;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [DataBits-1:0] operand_a;
    logic signed [DataBits-1:0] operand_b;
  } alu_op_t;

  typedef struct packed {
    logic signed [DataBits-1:0] result_raw;
    logic                       compare_true;
    logic                       overflow;
    logic                       divide_by_zero;
  } alu_res_t;
endpackage

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations through the request channel, predicts
// each result with exact integer arithmetic and checks the result stream in
// order, with random gaps on both sides and one long result stall.
// ----------------------------------------------------------------------------
module tb;
  import fxa_pkg::*;
  import fxa_tb_pkg::*;

  localparam int FRAC      = FractionBitsD;
  localparam int WDOG_MAX  = 5000;

  logic clk;
  logic rst_n;

  fxa_req_if in_ch ();
  fxa_rsp_if out_ch ();

  fixed_point_alu DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       error_count;
  int       send_gap;
  int       recv_gap;
  int       hold_off;
  int       hold_count;
  int       idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip_word(longint v, ref bit ovf);
    longint hi = 64'sd2147483647;
    longint lo = -64'sd2147483648;
    if (v > hi) begin
      ovf = 1'b1;
      return hi;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic alu_res_t compute_alu(alu_op_t op);
    alu_res_t r;
    longint a, b, p, q, m, n, d, rem;
    bit ovf;
    a = op.operand_a;
    b = op.operand_b;
    ovf = 1'b0;
    r = '0;
    case (op.cmd)
      CMD_ADD: r.result_raw = DataBits'(clip_word(a + b, ovf));
      CMD_SUB: r.result_raw = DataBits'(clip_word(a - b, ovf));
      CMD_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        q = (m + ((64'sd1 << FRAC) >>> 1)) >>> FRAC;
        r.result_raw = DataBits'(clip_word((p < 0) ? -q : q, ovf));
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
          r.result_raw = (a > 0) ? 32'sh7fffffff : (a < 0) ? 32'sh80000000 : '0;
        end else begin
          n = ((a < 0) ? -a : a) << FRAC;
          d = (b < 0) ? -b : b;
          q = n / d;
          rem = n % d;
          if (rem >= d - rem) q++;
          r.result_raw = DataBits'(clip_word(((a < 0) != (b < 0)) ? -q : q, ovf));
        end
      end
      CMD_GT: r.compare_true = a > b;
      CMD_LT: r.compare_true = a < b;
      CMD_GE: r.compare_true = a >= b;
      CMD_LE: r.compare_true = a <= b;
      CMD_EQ: r.compare_true = a == b;
      CMD_NE: r.compare_true = a != b;
      CMD_MIN: r.result_raw = DataBits'((a < b) ? a : b);
      CMD_MAX: r.result_raw = DataBits'((a > b) ? a : b);
      CMD_INC: r.result_raw = DataBits'(clip_word(a + 1, ovf));
      CMD_DEC: r.result_raw = DataBits'(clip_word(a - 1, ovf));
      CMD_FROM_INT: r.result_raw = DataBits'(clip_word(a * (64'sd1 << FRAC), ovf));
      default: r.result_raw = DataBits'(a >>> FRAC);
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 1023) - 512;
      3: return ($urandom_range(0, 255) - 128) << FRAC;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(cmd_t c, logic [31:0] a, logic [31:0] b);
    alu_op_t op;
    op.cmd = c;
    op.operand_a = a;
    op.operand_b = b;
    pending_ops.push_back(op);
  endtask

  // Driver: offers the head of the queue after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // Hold the transaction until the ALU takes it.
    end else begin
      // The accepted transaction leaves the queue, so the next one is at its head.
      if (in_ch.valid) begin
        expected_results.push_back(compute_alu(pending_ops.pop_front()));
      end
      if (send_gap > 0 || pending_ops.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.cmd <= pending_ops[0].cmd;
        in_ch.operand_a <= pending_ops[0].operand_a;
        in_ch.operand_b <= pending_ops[0].operand_b;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Monitor: checks accepted results and paces ready.
  always @(posedge clk) begin
    alu_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("outstanding transactions", 0, 1);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_raw !== want.result_raw)
            report_mismatch("result_raw", out_ch.result_raw, want.result_raw);
          if (out_ch.compare_true !== want.compare_true)
            report_mismatch("compare_true", out_ch.compare_true, want.compare_true);
          if (out_ch.overflow !== want.overflow)
            report_mismatch("overflow", out_ch.overflow, want.overflow);
          if (out_ch.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", out_ch.divide_by_zero, want.divide_by_zero);
        end
      end
      if (hold_off > 0 && hold_count < hold_off) begin
        hold_count <= hold_count + 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready)
          recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_t c;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    error_count = 0;
    hold_off = 0;
    idle_cycles = 0;

    // Directed: extremes, rounding ties, saturation and divide by zero.
    add_op(CMD_ADD, 32'h7fffffff, 32'h00000001);
    add_op(CMD_ADD, 32'h80000000, 32'hffffffff);
    add_op(CMD_SUB, 32'h80000000, 32'h00000001);
    add_op(CMD_SUB, 32'h7fffffff, 32'h80000000);
    add_op(CMD_MUL, 32'h00000180, 32'h00000080);
    add_op(CMD_MUL, 32'hfffffe80, 32'h00000080);
    add_op(CMD_MUL, 32'h80000000, 32'h80000000);
    add_op(CMD_MUL, 32'h7fffffff, 32'h80000000);
    add_op(CMD_DIV, 32'h00000100, 32'h00000000);
    add_op(CMD_DIV, 32'hffffff00, 32'h00000000);
    add_op(CMD_DIV, 32'h00000000, 32'h00000000);
    add_op(CMD_DIV, 32'h80000000, 32'hffffffff);
    add_op(CMD_DIV, 32'h00000001, 32'h00000200);
    add_op(CMD_DIV, 32'hffffffff, 32'h00000200);
    add_op(CMD_INC, 32'h7fffffff, 32'h0);
    add_op(CMD_DEC, 32'h80000000, 32'hffffffff);
    add_op(CMD_FROM_INT, 32'h00800000, 32'h0);
    add_op(CMD_FROM_INT, 32'hff7fffff, 32'h0);
    add_op(CMD_TO_INT, 32'hffffffff, 32'h0);
    add_op(CMD_TO_INT, 32'h7fffffff, 32'h0);
    for (int i = CMD_GT; i <= CMD_MAX; i++) begin
      c = cmd_t'(i);
      add_op(c, 32'h80000000, 32'h7fffffff);
    end
    for (int i = 0; i < 650; i++) begin
      c = cmd_t'($urandom_range(0, 15));
      add_op(c, rand_operand(), ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand());
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Long result stall partway through so that the pipeline fills.
    wait (pending_ops.size() < 400);
    @(posedge clk);
    hold_off <= 200;

    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
